/* hw/rtl/mcc_pkg.sv */
// Shared types, codes and microcode table for the minimum coin change block.
// Used by the sequencer, the datapath, the top level and the checker.
package mcc_pkg;

	localparam int AMT_W          = 10;
	localparam int CNT_W          = 10;
	localparam int COIN_W         = 10;
	localparam int CCNT_W         = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 10;
	localparam int DEF_MAX_AMOUNT = 1023;
	localparam int DEF_COIN_SLOTS = 6;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_COIN_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_0 = 3'd1;

	localparam logic [CCNT_W-1:0] RST_COIN_COUNT = 3'd3;

	typedef logic [2:0] step_t;
	typedef logic [2:0] op_t;
	typedef logic [2:0] cond_t;

	localparam step_t ST_IDLE  = 3'd0;
	localparam step_t ST_CHECK = 3'd1;
	localparam step_t ST_INIT  = 3'd2;
	localparam step_t ST_COIN  = 3'd3;
	localparam step_t ST_WRITE = 3'd4;
	localparam step_t ST_BAD   = 3'd5;
	localparam step_t ST_OUT   = 3'd6;

	localparam op_t OP_NONE   = 3'd0;
	localparam op_t OP_ACCEPT = 3'd1;
	localparam op_t OP_INIT   = 3'd2;
	localparam op_t OP_COIN   = 3'd3;
	localparam op_t OP_WRITE  = 3'd4;
	localparam op_t OP_BAD    = 3'd5;
	localparam op_t OP_OUT    = 3'd6;

	localparam cond_t C_ALWAYS     = 3'd0;
	localparam cond_t C_IN         = 3'd1;
	localparam cond_t C_TGT_BAD    = 3'd2;
	localparam cond_t C_TGT_ZERO   = 3'd3;
	localparam cond_t C_MORE_COINS = 3'd4;
	localparam cond_t C_MORE_AMT   = 3'd5;
	localparam cond_t C_OUT_FREE   = 3'd6;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t tgt;
		step_t nxt;
	} uword_t;

	typedef struct packed {
		logic in_fire;
		logic tgt_bad;
		logic tgt_zero;
		logic more_coins;
		logic more_amt;
		logic out_free;
	} status_t;

	function automatic uword_t ucode(input step_t step);
		uword_t w;
		case (step)
			ST_IDLE:  w = '{OP_ACCEPT, C_IN,         ST_CHECK, ST_IDLE};
			ST_CHECK: w = '{OP_NONE,   C_TGT_BAD,    ST_BAD,   ST_INIT};
			ST_INIT:  w = '{OP_INIT,   C_TGT_ZERO,   ST_OUT,   ST_COIN};
			ST_COIN:  w = '{OP_COIN,   C_MORE_COINS, ST_COIN,  ST_WRITE};
			ST_WRITE: w = '{OP_WRITE,  C_MORE_AMT,   ST_COIN,  ST_OUT};
			ST_BAD:   w = '{OP_BAD,    C_ALWAYS,     ST_OUT,   ST_OUT};
			ST_OUT:   w = '{OP_OUT,    C_OUT_FREE,   ST_IDLE,  ST_OUT};
			default:  w = '{OP_NONE,   C_ALWAYS,     ST_IDLE,  ST_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [COIN_W-1:0] coin_reset(input int slot);
		logic [COIN_W-1:0] v;
		case (slot)
			0:       v = 10'd5;
			1:       v = 10'd3;
			2:       v = 10'd2;
			default: v = 10'd1;
		endcase
		return v;
	endfunction

endpackage

/* hw/rtl/min_coin_change_dp.sv */
// Top level of the minimum coin change block: configuration registers,
// microcode sequencer and datapath. Depends on mcc_pkg, mcc_seq, mcc_datapath.
//
//  channel  | signals                                   | transfer
//  ---------+-------------------------------------------+----------------------
//  input    | in_valid, in_ready, target_amount         | valid & ready
//  output   | out_valid, out_ready, fewest_coins, reach.| valid & ready
//  config   | cfg_we, cfg_index, cfg_data               | cfg_we, no wait
//
// A request of target T with n coins in use steps through amounts 1 to T,
// one coin per cycle through the single read port of the count table, with a
// write step per amount. Targets of zero or above the table skip the coin loop.
// Reset needs no table pass; each request writes entries before it reads them.
// The output register holds a result under stall while the next request is taken.
module min_coin_change_dp
	import mcc_pkg::*;
#(
	parameter int MAX_AMOUNT = DEF_MAX_AMOUNT,
	parameter int COIN_SLOTS = DEF_COIN_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [AMT_W-1:0]      target_amount,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CNT_W-1:0]      fewest_coins,
	output logic                  reachable
);

	logic [CCNT_W-1:0] coin_count_q;
	logic [COIN_W-1:0] coin_value_q [COIN_SLOTS];
	status_t           status;
	op_t               op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coin_count_q <= RST_COIN_COUNT;
			for (int i = 0; i < COIN_SLOTS; i++) begin
				coin_value_q[i] <= coin_reset(i);
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_COIN_COUNT) begin
				coin_count_q <= cfg_data[CCNT_W-1:0];
			end
			for (int i = 0; i < COIN_SLOTS; i++) begin
				if (cfg_index == CFG_IDX_W'(int'(REG_COIN_VALUE_0) + i)) begin
					coin_value_q[i] <= cfg_data[COIN_W-1:0];
				end
			end
		end
	end

	mcc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	mcc_datapath #(
		.MAX_AMOUNT (MAX_AMOUNT),
		.COIN_SLOTS (COIN_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.status        (status),
		.coin_count    (coin_count_q),
		.coin_value    (coin_value_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.target_amount (target_amount),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fewest_coins  (fewest_coins),
		.reachable     (reachable)
	);

endmodule

/* hw/rtl/mcc_seq.sv */
// Microcode sequencer: step counter, control store and jump condition select.
// Depends on mcc_pkg for the control word and status types.
module mcc_seq
	import mcc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output op_t     op
);

	step_t  upc_q;
	uword_t word;
	logic   hit;

	assign word = ucode(upc_q);
	assign op   = word.op;

	always_comb begin
		case (word.cond)
			C_ALWAYS:     hit = 1'b1;
			C_IN:         hit = status.in_fire;
			C_TGT_BAD:    hit = status.tgt_bad;
			C_TGT_ZERO:   hit = status.tgt_zero;
			C_MORE_COINS: hit = status.more_coins;
			C_MORE_AMT:   hit = status.more_amt;
			C_OUT_FREE:   hit = status.out_free;
			default:      hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_IDLE;
		end else begin
			upc_q <= hit ? word.tgt : word.nxt;
		end
	end

endmodule

/* hw/rtl/mcc_datapath.sv */
// Datapath: amount and coin counters, best-count table memory, compare unit
// and output register. Driven by op codes from mcc_seq; uses mcc_pkg.
module mcc_datapath
	import mcc_pkg::*;
#(
	parameter int MAX_AMOUNT = DEF_MAX_AMOUNT,
	parameter int COIN_SLOTS = DEF_COIN_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  op_t               op,
	output status_t           status,
	input  logic [CCNT_W-1:0] coin_count,
	input  logic [COIN_W-1:0] coin_value [COIN_SLOTS],
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [AMT_W-1:0]  target_amount,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CNT_W-1:0]  fewest_coins,
	output logic              reachable
);

	localparam int TOP_AMT = (MAX_AMOUNT < 1023) ? MAX_AMOUNT : 1023;
	localparam int DEPTH   = TOP_AMT + 1;
	localparam int AW      = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int JW      = (COIN_SLOTS > 1) ? $clog2(COIN_SLOTS) : 1;

	logic [CNT_W:0]        mem [DEPTH];
	logic [CNT_W:0]        rd_q;
	logic [AMT_W-1:0]      target_q;
	logic [AMT_W-1:0]      a_q;
	logic [CCNT_W-1:0]     j_q;
	logic [CCNT_W-1:0]     n_q;
	logic [CNT_W-1:0]      best_q;
	logic                  have_q;
	logic                  cand_s1;
	logic [CNT_W-1:0]      res_cnt_q;
	logic                  res_have_q;
	logic                  out_valid_q;
	logic [CNT_W-1:0]      out_cnt_q;
	logic                  out_have_q;

	logic                  in_fire;
	logic                  out_free;
	logic [COIN_W-1:0]     coin;
	logic                  cand_now;
	logic [AW-1:0]         raddr;
	logic [AW-1:0]         waddr;
	logic                  mem_we;
	logic [CNT_W:0]        wdata;
	logic [CNT_W-1:0]      cand_cnt;
	logic                  take;
	logic [CNT_W-1:0]      best_nx;
	logic                  have_nx;
	logic [CCNT_W-1:0]     n_in;

	assign in_ready = (op == OP_ACCEPT);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign n_in = (coin_count > CCNT_W'(COIN_SLOTS)) ? CCNT_W'(COIN_SLOTS) : coin_count;

	assign coin     = coin_value[j_q[JW-1:0]];
	assign cand_now = (j_q < n_q) && (coin != '0) && (coin <= a_q);
	assign raddr    = AW'(a_q - coin);

	assign cand_cnt = (rd_q[CNT_W-1:0] == COUNT_MAX) ? COUNT_MAX : rd_q[CNT_W-1:0] + 1'b1;
	assign take     = cand_s1 && rd_q[CNT_W] && (!have_q || (cand_cnt < best_q));
	assign best_nx  = take ? cand_cnt : best_q;
	assign have_nx  = have_q || take;

	assign mem_we = (op == OP_INIT) || (op == OP_WRITE);
	assign waddr  = (op == OP_INIT) ? '0 : AW'(a_q);
	assign wdata  = (op == OP_INIT) ? {1'b1, {CNT_W{1'b0}}}
	                                : {have_nx, (have_nx ? best_nx : {CNT_W{1'b0}})};

	assign status.in_fire    = in_fire;
	assign status.tgt_bad    = 32'(target_q) > MAX_AMOUNT;
	assign status.tgt_zero   = (target_q == '0);
	assign status.more_coins = ({1'b0, j_q} + 1'b1) < {1'b0, n_q};
	assign status.more_amt   = (a_q < target_q);
	assign status.out_free   = out_free;

	assign out_valid    = out_valid_q;
	assign fewest_coins = out_cnt_q;
	assign reachable    = out_have_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			target_q <= target_amount;
			n_q      <= n_in;
		end
		case (op)
			OP_INIT: begin
				a_q        <= AMT_W'(1);
				j_q        <= '0;
				best_q     <= '0;
				have_q     <= 1'b0;
				res_cnt_q  <= '0;
				res_have_q <= 1'b1;
			end
			OP_COIN: begin
				j_q    <= j_q + 1'b1;
				best_q <= best_nx;
				have_q <= have_nx;
			end
			OP_WRITE: begin
				a_q        <= a_q + 1'b1;
				j_q        <= '0;
				best_q     <= '0;
				have_q     <= 1'b0;
				res_cnt_q  <= have_nx ? best_nx : '0;
				res_have_q <= have_nx;
			end
			OP_BAD: begin
				res_cnt_q  <= '0;
				res_have_q <= 1'b0;
			end
			default: begin
			end
		endcase
		if ((op == OP_OUT) && out_free) begin
			out_cnt_q  <= res_cnt_q;
			out_have_q <= res_have_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cand_s1 <= (op == OP_COIN) && cand_now;
			if ((op == OP_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/mcc_checker.sv */
// Port-level checks for min_coin_change_dp, attached by a bind.
// Depends on mcc_pkg for field widths.
module mcc_checker
	import mcc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [CNT_W-1:0] fewest_coins,
	input logic             reachable
);

	logic [1:0] pend_q;
	logic       in_fire;
	logic       out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_fire) - 2'(out_fire);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fewest_coins) && $stable(reachable))
		else $error("result changed under stall");

	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reachable |-> fewest_coins == '0)
		else $error("unreachable result with nonzero count");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one is at work");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result without a request");

endmodule

bind min_coin_change_dp mcc_checker u_mcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.fewest_coins (fewest_coins),
	.reachable    (reachable)
);

/* sim/min_coin_change_dp_test.sv */
// Self-checking testbench for min_coin_change_dp: directed table, then random coin sets and requests.
// Expected answers come from the directed table or an in-bench dynamic-programming predictor.
// Depends on mcc_pkg and the min_coin_change_dp RTL only.
module min_coin_change_dp_test
	import mcc_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 10;
	localparam int MAX_GAP      = 11;
	localparam int DRAIN_CYCLES = 50;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS  = 12;
	localparam int HOLD_PHASE   = 3;
	localparam int PAUSE_PHASE  = 6;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_COIN_VALUE_0 + CFG_IDX_W'(DEF_COIN_SLOTS);

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             reach;
	} coin_result_t;

	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [AMT_W-1:0]      amt;
		logic                  known;
		coin_result_t          want;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [AMT_W-1:0]      target_amount = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [CNT_W-1:0]      fewest_coins;
	logic                  reachable;

	logic [CCNT_W-1:0] coin_sel = RST_COIN_COUNT;
	logic [COIN_W-1:0] coin_val [DEF_COIN_SLOTS] = '{10'd5, 10'd3, 10'd2, 10'd1, 10'd1, 10'd1};

	coin_result_t predicted_answers [$];
	int  mismatches = 0;
	bit  tx_no_gaps = 1'b0;
	bit  rx_no_gaps = 1'b0;
	bit  hold_req = 1'b0;

	min_coin_change_dp dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.target_amount(target_amount),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fewest_coins (fewest_coins),
		.reachable    (reachable)
	);

	always #(HALF_PERIOD) clk = ~clk;

	initial begin
		#100_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic coin_result_t fewest_coins_for(input logic [AMT_W-1:0] amt);
		logic [CNT_W:0]   tbl [0:DEF_MAX_AMOUNT];
		int               n;
		int               c;
		int               cand;
		logic             have;
		logic [CNT_W-1:0] best;
		coin_result_t     r;
		n = (coin_sel > DEF_COIN_SLOTS) ? DEF_COIN_SLOTS : int'(coin_sel);
		tbl[0] = {1'b1, {CNT_W{1'b0}}};
		for (int a = 1; a <= int'(amt); a++) begin
			have = 1'b0;
			best = '0;
			for (int j = 0; j < n; j++) begin
				c = int'(coin_val[j]);
				if (c != 0 && c <= a) begin
					if (tbl[a - c][CNT_W]) begin
						cand = int'(tbl[a - c][CNT_W-1:0]) + 1;
						if (cand > int'(COUNT_MAX))
							cand = int'(COUNT_MAX);
						if (!have || cand < int'(best)) begin
							best = CNT_W'(cand);
							have = 1'b1;
						end
					end
				end
			end
			tbl[a] = have ? {1'b1, best} : '0;
		end
		r.reach = tbl[amt][CNT_W];
		r.count = r.reach ? tbl[amt][CNT_W-1:0] : '0;
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic row_t ask_row(input logic [AMT_W-1:0] amt);
		row_t r;
		r = '0;
		r.amt = amt;
		return r;
	endfunction

	function automatic row_t known_row(input logic [AMT_W-1:0] amt,
			input logic [CNT_W-1:0] count, input logic reach);
		row_t r;
		r = '0;
		r.amt = amt;
		r.known = 1'b1;
		r.want = '{count, reach};
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_COIN_COUNT)
			coin_sel = data[CCNT_W-1:0];
		else if (idx != REG_UNUSED)
			coin_val[idx - REG_COIN_VALUE_0] = data;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (predicted_answers.size() != 0);
	endtask

	task automatic send_amount(input logic [AMT_W-1:0] amt, input logic known,
			input coin_result_t want);
		int gap;
		gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		target_amount <= amt;
		do
			@(posedge clk);
		while (!in_ready);
		predicted_answers.push_back(known ? want : fewest_coins_for(amt));
	endtask

	task automatic pick_coins();
		int pick;
		logic [COIN_W-1:0] v;
		pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 6);
		put_reg(REG_COIN_COUNT,
			(CFG_DATA_W'($urandom_range(0, 127)) << CCNT_W) | CFG_DATA_W'(pick));
		for (int k = 0; k < DEF_COIN_SLOTS; k++) begin
			case ($urandom_range(0, 9))
				0:       v = '0;
				1:       v = COIN_W'($urandom_range(0, 1023));
				default: v = COIN_W'($urandom_range(1, 16));
			endcase
			put_reg(REG_COIN_VALUE_0 + CFG_IDX_W'(k), v);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int               gap;
		int               hold_len;
		coin_result_t     want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = rx_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0 || hold_req)
				out_ready <= 1'b0;
			if (hold_req) begin
				hold_len = $urandom_range(300, 500);
				repeat (hold_len) @(posedge clk);
				hold_req = 1'b0;
			end
			repeat (gap) @(posedge clk);
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			if (predicted_answers.size() == 0) begin
				report_mismatch("result with no request pending", int'(fewest_coins), 0);
			end else begin
				want = predicted_answers.pop_front();
				if (fewest_coins !== want.count)
					report_mismatch("fewest_coins", int'(fewest_coins), int'(want.count));
				if (reachable !== want.reach)
					report_mismatch("reachable", int'(reachable), int'(want.reach));
			end
		end
	end

	initial begin
		row_t             rows [$];
		logic             cfg_open;
		logic [AMT_W-1:0] amt;

		rows.push_back(known_row(10'd0, 10'd0, 1'b1));
		rows.push_back(known_row(10'd1, 10'd0, 1'b0));
		rows.push_back(known_row(10'd1023, 10'd205, 1'b1));
		rows.push_back(ask_row(10'd7));
		rows.push_back(ask_row(10'd4));
		rows.push_back(cfg_row(REG_COIN_COUNT, 10'd1));
		rows.push_back(cfg_row(REG_COIN_VALUE_0, 10'd1));
		rows.push_back(known_row(10'd1023, 10'd1023, 1'b1));
		rows.push_back(ask_row(10'd512));
		rows.push_back(cfg_row(REG_COIN_COUNT, 10'd0));
		rows.push_back(known_row(10'd0, 10'd0, 1'b1));
		rows.push_back(known_row(10'd5, 10'd0, 1'b0));
		rows.push_back(cfg_row(REG_COIN_COUNT, 10'h3FF));
		rows.push_back(cfg_row(REG_COIN_VALUE_0, 10'd1023));
		rows.push_back(cfg_row(REG_COIN_VALUE_0 + 3'd1, 10'd0));
		rows.push_back(cfg_row(REG_COIN_VALUE_0 + 3'd2, 10'd7));
		rows.push_back(cfg_row(REG_COIN_VALUE_0 + 3'd3, 10'd11));
		rows.push_back(cfg_row(REG_COIN_VALUE_0 + 3'd4, 10'd13));
		rows.push_back(cfg_row(REG_COIN_VALUE_0 + 3'd5, 10'd512));
		rows.push_back(known_row(10'd1, 10'd0, 1'b0));
		rows.push_back(known_row(10'd1023, 10'd1, 1'b1));
		rows.push_back(known_row(10'd6, 10'd0, 1'b0));
		rows.push_back(ask_row(10'd700));
		rows.push_back(ask_row(10'd45));
		rows.push_back(cfg_row(REG_UNUSED, 10'd1));
		rows.push_back(known_row(10'd1, 10'd0, 1'b0));
		rows.push_back(cfg_row(REG_COIN_COUNT, 10'd2));
		rows.push_back(cfg_row(REG_COIN_VALUE_0, 10'd0));
		rows.push_back(cfg_row(REG_COIN_VALUE_0 + 3'd1, 10'd0));
		rows.push_back(known_row(10'd3, 10'd0, 1'b0));
		rows.push_back(known_row(10'd0, 10'd0, 1'b1));
		rows.push_back(cfg_row(REG_COIN_COUNT, 10'd4));
		rows.push_back(cfg_row(REG_COIN_VALUE_0, 10'h155));
		rows.push_back(cfg_row(REG_COIN_VALUE_0 + 3'd1, 10'h2AA));
		rows.push_back(cfg_row(REG_COIN_VALUE_0 + 3'd2, 10'd3));
		rows.push_back(cfg_row(REG_COIN_VALUE_0 + 3'd3, 10'd2));
		rows.push_back(ask_row(10'd1000));
		rows.push_back(ask_row(10'h2AA));
		rows.push_back(ask_row(10'h155));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cfg_open = 1'b0;
		for (int i = 0; i < rows.size(); i++) begin
			if (rows[i].is_cfg) begin
				if (!cfg_open)
					wait_idle();
				put_reg(rows[i].idx, rows[i].data);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open)
					cfg_we <= 1'b0;
				cfg_open = 1'b0;
				send_amount(rows[i].amt, rows[i].known, rows[i].want);
			end
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			pick_coins();
			tx_no_gaps = (phase == 2);
			rx_no_gaps = (phase == 2 || phase == 5);
			if (phase == HOLD_PHASE)
				hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (phase == PAUSE_PHASE && k == PHASE_ITEMS / 2)
					wait_idle();
				if (phase == HOLD_PHASE)
					amt = AMT_W'($urandom_range(0, 15));
				else if ($urandom_range(0, 9) == 0)
					amt = AMT_W'($urandom_range(0, 1023));
				else
					amt = AMT_W'($urandom_range(0, 40));
				send_amount(amt, 1'b0, '0);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && predicted_answers.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
